// ===== hdl/ttw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttw_pkg
// Shared types, sizes and codes for the text terminal writer.
// ----------------------------------------------------------------------------
package ttw_pkg;

   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;
   localparam int CELLS   = ROWS * COLUMNS;

   localparam int COL_W  = $clog2(COLUMNS);
   localparam int ROW_W  = $clog2(ROWS);
   localparam int CELL_W = $clog2(CELLS);
   localparam int POS_W  = 11;
   localparam int CMP_W  = (CELL_W > POS_W) ? CELL_W : POS_W;
   localparam int DATA_W = 16;

   localparam logic [1:0] MODE_PUT   = 2'd0;
   localparam logic [1:0] MODE_READ  = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;

   localparam logic [7:0] CHAR_NEWLINE   = 8'd10;
   localparam logic [7:0] CHAR_BACKSPACE = 8'd8;
   localparam logic [7:0] CHAR_BLANK     = 8'h20;
   localparam logic [7:0] RESET_COLOR    = 8'h0F;

   typedef struct packed {
      logic [1:0]       mode;
      logic [7:0]       char_code;
      logic [POS_W-1:0] cell_address;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic [POS_W-1:0]  cursor_pos;
   } rsp_type;

   typedef struct packed {
      logic              we;
      logic [CELL_W-1:0] waddr;
      logic [DATA_W-1:0] wdata;
      logic              re;
      logic [CELL_W-1:0] raddr;
   } mem_req_type;

   function automatic logic [CELL_W-1:0] cell_index(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
      return CELL_W'(row) * CELL_W'(COLUMNS) + CELL_W'(col);
   endfunction

endpackage

// ===== hdl/ttw_screen_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttw_screen_ram
// Screen store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ttw_screen_ram (
   input  logic                       clock,
   input  ttw_pkg::mem_req_type       mem_req,
   output logic [ttw_pkg::DATA_W-1:0] rdata
);
   import ttw_pkg::*;

   logic [DATA_W-1:0] mem [CELLS];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem[mem_req.waddr] <= mem_req.wdata;
      end
      if (mem_req.re) begin
         rdata_ff <= mem[mem_req.raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/ttw_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttw_engine
// Cursor state and sequencer: reset fill, puts, reads, scroll and clear sweeps.
// ----------------------------------------------------------------------------
module ttw_engine (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [7:0]                 csr_wr_data,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  ttw_pkg::req_type           req,
   output logic                       res_valid,
   input  logic                       res_ready,
   output ttw_pkg::rsp_type           res,
   output ttw_pkg::mem_req_type       mem_req,
   input  logic [ttw_pkg::DATA_W-1:0] rdata
);
   import ttw_pkg::*;

   localparam logic [2:0] ST_INIT   = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_READ   = 3'd2;
   localparam logic [2:0] ST_SCROLL = 3'd3;
   localparam logic [2:0] ST_FILL   = 3'd4;
   localparam logic [2:0] ST_CLEAR  = 3'd5;
   localparam logic [2:0] ST_DONE   = 3'd6;

   localparam logic [CELL_W-1:0] LAST_CELL = CELL_W'(CELLS - 1);
   localparam logic [CELL_W-1:0] LAST_ROW0 = CELL_W'(CELLS - COLUMNS);
   localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);
   localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLUMNS - 1);

   logic [2:0]        state_ff, state_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [CELL_W-1:0] ptr_ff, ptr_in;
   logic              pend_ff, pend_in;
   logic [CELL_W-1:0] wa_ff, wa_in;
   logic [DATA_W-1:0] data_ff, data_in;
   logic              rd_ok_ff, rd_ok_in;
   logic [7:0]        color_ff, color_in;

   logic [DATA_W-1:0] blank;
   logic [CELL_W-1:0] cur_idx;
   logic [ROW_W-1:0]  bs_row;
   logic [COL_W-1:0]  bs_col;

   assign blank   = {color_ff, CHAR_BLANK};
   assign cur_idx = cell_index(row_ff, col_ff);

   // backspace target: step left, wrap up a row, stop at home
   always_comb begin
      bs_row = row_ff;
      bs_col = col_ff;
      if (col_ff != '0) begin
         bs_col = col_ff - COL_W'(1);
      end else if (row_ff != '0) begin
         bs_row = row_ff - ROW_W'(1);
         bs_col = LAST_COL;
      end
   end

   always_comb begin
      color_in = csr_wr_en ? csr_wr_data : color_ff;
   end

   always_comb begin
      state_in  = state_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      ptr_in    = ptr_ff;
      pend_in   = pend_ff;
      wa_in     = wa_ff;
      data_in   = data_ff;
      rd_ok_in  = rd_ok_ff;
      mem_req   = '0;
      req_ready = (state_ff == ST_IDLE);
      res_valid = 1'b0;
      res       = '0;

      unique case (state_ff) inside
         ST_INIT: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = ptr_ff;
            mem_req.wdata = {RESET_COLOR, CHAR_BLANK};
            if (ptr_ff == LAST_CELL) begin
               ptr_in   = '0;
               state_in = ST_IDLE;
            end else begin
               ptr_in = ptr_ff + CELL_W'(1);
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               data_in  = '0;
               state_in = ST_DONE;
               case (req.mode)
                  MODE_PUT: begin
                     if (req.char_code == CHAR_NEWLINE) begin
                        col_in = '0;
                        if (row_ff == LAST_ROW) begin
                           ptr_in   = '0;
                           pend_in  = 1'b0;
                           state_in = ST_SCROLL;
                        end else begin
                           row_in = row_ff + ROW_W'(1);
                        end
                     end else if (req.char_code == CHAR_BACKSPACE) begin
                        row_in        = bs_row;
                        col_in        = bs_col;
                        mem_req.we    = 1'b1;
                        mem_req.waddr = cell_index(bs_row, bs_col);
                        mem_req.wdata = blank;
                     end else begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = cur_idx;
                        mem_req.wdata = {color_ff, req.char_code};
                        if (col_ff == LAST_COL) begin
                           col_in = '0;
                           if (row_ff == LAST_ROW) begin
                              ptr_in   = '0;
                              pend_in  = 1'b0;
                              state_in = ST_SCROLL;
                           end else begin
                              row_in = row_ff + ROW_W'(1);
                           end
                        end else begin
                           col_in = col_ff + COL_W'(1);
                        end
                     end
                  end
                  MODE_READ: begin
                     rd_ok_in      = (CMP_W'(req.cell_address) < CMP_W'(CELLS));
                     mem_req.re    = 1'b1;
                     mem_req.raddr = CELL_W'(req.cell_address);
                     state_in      = ST_READ;
                  end
                  MODE_CLEAR: begin
                     row_in   = '0;
                     col_in   = '0;
                     ptr_in   = '0;
                     state_in = ST_CLEAR;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_READ: begin
            data_in  = rd_ok_ff ? rdata : '0;
            state_in = ST_DONE;
         end
         ST_SCROLL: begin
            // write follows in the cycle after its read, always to a lower address
            if (pend_ff) begin
               mem_req.we    = 1'b1;
               mem_req.waddr = wa_ff;
               mem_req.wdata = rdata;
            end
            if (ptr_ff == LAST_ROW0) begin
               pend_in  = 1'b0;
               state_in = ST_FILL;
            end else begin
               mem_req.re    = 1'b1;
               mem_req.raddr = ptr_ff + CELL_W'(COLUMNS);
               pend_in       = 1'b1;
               wa_in         = ptr_ff;
               ptr_in        = ptr_ff + CELL_W'(1);
            end
         end
         ST_FILL, ST_CLEAR: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = ptr_ff;
            mem_req.wdata = blank;
            if (ptr_ff == LAST_CELL) begin
               ptr_in   = '0;
               state_in = ST_DONE;
            end else begin
               ptr_in = ptr_ff + CELL_W'(1);
            end
         end
         ST_DONE: begin
            res_valid     = 1'b1;
            res.read_data = data_ff;
            res.cursor_pos = POS_W'(cur_idx);
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         row_ff   <= '0;
         col_ff   <= '0;
         ptr_ff   <= '0;
         pend_ff  <= 1'b0;
         color_ff <= RESET_COLOR;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         ptr_ff   <= ptr_in;
         pend_ff  <= pend_in;
         color_ff <= color_in;
      end
   end

   always_ff @(posedge clock) begin
      wa_ff    <= wa_in;
      data_ff  <= data_in;
      rd_ok_ff <= rd_ok_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      row_ff < LAST_ROW + ROW_W'(1) || row_ff == LAST_ROW)
      else $error("cursor row out of range");

   assert property (@(posedge clock) disable iff (reset)
      mem_req.we && mem_req.re |-> mem_req.waddr < mem_req.raddr)
      else $error("scroll write overtakes its read");

   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req.mode == MODE_CLEAR |=> state_ff == ST_CLEAR
         && row_ff == '0 && col_ff == '0)
      else $error("clear did not home the cursor");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCROLL && $past(state_ff) == ST_SCROLL && !pend_ff
         |-> ptr_ff == LAST_ROW0)
      else $error("scroll lost a pending move");

endmodule

// ===== hdl/text_terminal_writer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_terminal_writer
// Text-mode console engine over a ROWS x COLUMNS store of 16-bit cells.
// ----------------------------------------------------------------------------
//  channel   ports                              direction
//  request   req_valid / req_ready / req_payload  in
//  response  rsp_valid / rsp_ready / rsp_payload  out
//  csr       csr_wr_en / csr_wr_data              in  (text color)
//
//  plain character, backspace, newline without scroll, mode 3: straight to the response
//  cell read: through a read state for the registered store read
//  clear: a sweep over all CELLS, one store write per cycle
//  newline or wrap on the last row: the scroll sweep, then a blank fill of the last row
//  after reset a pass fills the store before req_ready rises
//  the response register lets the next request start while one waits
// ----------------------------------------------------------------------------
module text_terminal_writer (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [7:0]       csr_wr_data,
   input  logic             req_valid,
   output logic             req_ready,
   input  ttw_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ttw_pkg::rsp_type rsp_payload
);
   import ttw_pkg::*;

   mem_req_type       mem_req;
   logic [DATA_W-1:0] rdata;
   logic              res_valid;
   logic              res_ready;
   rsp_type           res;

   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_payload_ff, rsp_payload_in;

   ttw_screen_ram u_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rdata   (rdata)
   );

   ttw_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req         (req_payload),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res         (res),
      .mem_req     (mem_req),
      .rdata       (rdata)
   );

   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (res_ready) begin
         rsp_valid_in   = res_valid;
         rsp_payload_in = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// ===== tb/tb_text_terminal_writer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_terminal_writer
// Self-checking bench for the text terminal writer. A shadow copy of the
// screen, cursor and text color is kept, the first two updated on every
// accepted request, and gives the expected response. Responses are
// compared field by field in order. Stimulus is a directed opening (reset
// contents, reads beyond the screen, unused mode, backspace at home, wraps,
// clear) followed by random text with newline runs and long lines that
// drive scrolling. Six text colors are used, including both extremes. Both
// channels idle in random bursts, except in the last phase.
// ----------------------------------------------------------------------------
module tb_text_terminal_writer;
   import ttw_pkg::*;

   localparam logic [1:0]        MODE_UNUSED = 2'd3;
   localparam logic [DATA_W-1:0] RESET_CELL  = {RESET_COLOR, CHAR_BLANK};
   localparam int                MAX_REPORTS = 40;
   localparam int                PHASES      = 5;
   localparam int                PHASE_ITEMS = 200;

   class terminal_shadow;
      logic [DATA_W-1:0] screen [CELLS];
      int unsigned       row;
      int unsigned       col;
      logic [7:0]        color;
      rsp_type           awaited_rsp [$];
      int unsigned       errors;
      int unsigned       responses;
      int unsigned       puts;
      int unsigned       reads;
      int unsigned       clears;
      int unsigned       unused;
      int unsigned       scrolls;
      longint unsigned   cost;

      function new();
         foreach (screen[i]) screen[i] = RESET_CELL;
         row = 0;
         col = 0;
         color = RESET_COLOR;
      endfunction

      function logic [DATA_W-1:0] blank();
         return {color, CHAR_BLANK};
      endfunction

      function int unsigned pending();
         return awaited_rsp.size();
      endfunction

      function void advance_row();
         row++;
         if (row >= ROWS) begin
            for (int i = 0; i < CELLS - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
            for (int i = CELLS - COLUMNS; i < CELLS; i++) screen[i] = blank();
            row = ROWS - 1;
            scrolls++;
            cost += CELLS + 2;
         end
      endfunction

      function void note_request(req_type r);
         rsp_type exp_rsp;
         exp_rsp.read_data = '0;
         // own cycles plus worst gap and stall
         cost += 24;
         case (r.mode)
            MODE_PUT: begin
               puts++;
               if (r.char_code == CHAR_NEWLINE) begin
                  col = 0;
                  advance_row();
               end else if (r.char_code == CHAR_BACKSPACE) begin
                  if (col > 0) begin
                     col--;
                  end else if (row > 0) begin
                     row--;
                     col = COLUMNS - 1;
                  end
                  screen[row * COLUMNS + col] = blank();
               end else begin
                  screen[row * COLUMNS + col] = {color, r.char_code};
                  col++;
                  if (col >= COLUMNS) begin
                     col = 0;
                     advance_row();
                  end
               end
            end
            MODE_READ: begin
               reads++;
               if (r.cell_address < CELLS) exp_rsp.read_data = screen[r.cell_address];
            end
            MODE_CLEAR: begin
               clears++;
               cost += CELLS + 1;
               foreach (screen[i]) screen[i] = blank();
               row = 0;
               col = 0;
            end
            default: begin
               unused++;
            end
         endcase
         exp_rsp.cursor_pos = POS_W'(row * COLUMNS + col);
         awaited_rsp.push_back(exp_rsp);
      endfunction

      task report_mismatch(string msg);
         errors++;
         if (errors <= MAX_REPORTS) $display("MISMATCH at %0t: %s", $time, msg);
      endtask

      task check_response(rsp_type got);
         rsp_type exp_rsp;
         responses++;
         if (awaited_rsp.size() == 0) begin
            report_mismatch($sformatf("unexpected response data %h cursor %0d",
                                      got.read_data, got.cursor_pos));
            return;
         end
         exp_rsp = awaited_rsp.pop_front();
         if (got.read_data !== exp_rsp.read_data)
            report_mismatch($sformatf("response %0d read_data %h, expected %h",
                                      responses, got.read_data, exp_rsp.read_data));
         if (got.cursor_pos !== exp_rsp.cursor_pos)
            report_mismatch($sformatf("response %0d cursor_pos %0d, expected %0d",
                                      responses, got.cursor_pos, exp_rsp.cursor_pos));
      endtask
   endclass

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    csr_wr_en   = 1'b0;
   logic    [7:0] csr_wr_data = '0;
   logic    req_valid   = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready   = 1'b1;
   rsp_type rsp_payload;

   terminal_shadow  shadow;
   bit              quiet       = 1'b0;
   int unsigned     gap_pct     = 10;
   int unsigned     stall_pct   = 10;
   int unsigned     stall_left  = 0;
   longint unsigned cycle_count = 0;

   text_terminal_writer i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // limit grows with the work accepted so far; covers the fill pass after reset
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > 4 * (3 * CELLS + 2000 + shadow.cost)) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, shadow.pending());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) shadow.note_request(req_payload);
         if (rsp_valid && rsp_ready) shadow.check_response(rsp_payload);
      end
   end

   // receiver stalls in bursts, with calm stretches in between
   always @(negedge clock) begin
      if (reset || quiet) begin
         rsp_ready = 1'b1;
      end else if (stall_left != 0) begin
         rsp_ready = 1'b0;
         stall_left--;
      end else begin
         rsp_ready = 1'b1;
         if ($urandom_range(0, 299) == 0) stall_pct = ($urandom_range(0, 1) != 0) ? 12 : 0;
         if ($urandom_range(0, 99) < stall_pct) stall_left = $urandom_range(1, 10);
      end
   end

   task automatic send_request(input logic [1:0] mode, input logic [7:0] ch,
                               input logic [POS_W-1:0] addr);
      int unsigned gap;
      if (!quiet && $urandom_range(0, 99) < gap_pct) begin
         gap = $urandom_range(1, 10);
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_payload.mode         = mode;
      req_payload.char_code    = ch;
      req_payload.cell_address = addr;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic wait_drained();
      req_valid = 1'b0;
      while (shadow.pending() != 0) @(negedge clock);
   endtask

   task automatic write_color(input logic [7:0] value);
      csr_wr_data = value;
      csr_wr_en   = 1'b1;
      @(negedge clock);
      csr_wr_en   = 1'b0;
      shadow.color = value;
   endtask

   function automatic logic [7:0] pick_char();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 8) return CHAR_NEWLINE;
      if (roll < 14) return CHAR_BACKSPACE;
      return 8'($urandom);
   endfunction

   task automatic send_random_request();
      int unsigned      pick;
      int unsigned      here;
      logic [POS_W-1:0] addr;
      pick = $urandom_range(0, 999);
      addr = POS_W'($urandom);
      if (pick < 680) begin
         send_request(MODE_PUT, pick_char(), addr);
      end else if (pick < 950) begin
         here = shadow.row * COLUMNS + shadow.col;
         case ($urandom_range(0, 9))
            0:          addr = POS_W'($urandom_range(CELLS, 2 ** POS_W - 1));
            1, 2, 3, 4: addr = POS_W'($urandom_range(0, CELLS - 1));
            // near the cursor, where recent text landed
            default:    addr = POS_W'((here > 200) ? here - $urandom_range(0, 200)
                                                   : $urandom_range(0, here));
         endcase
         send_request(MODE_READ, 8'($urandom), addr);
      end else if (pick < 975) begin
         send_request(MODE_UNUSED, 8'($urandom), addr);
      end else if (pick < 978) begin
         send_request(MODE_CLEAR, 8'($urandom), addr);
      end else if (pick < 984) begin
         // hold off until the block has answered everything
         wait_drained();
         send_request(MODE_PUT, pick_char(), addr);
      end else begin
         send_request(MODE_PUT, pick_char(), addr);
      end
   endtask

   initial begin
      int unsigned burst_at;
      logic [7:0]  colors [PHASES];

      shadow = new();
      colors[0] = 8'h00;
      colors[1] = 8'hFF;
      for (int i = 2; i < PHASES; i++) colors[i] = 8'($urandom);

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed opening, reset color still in place
      send_request(MODE_READ, 8'h00, '0);
      send_request(MODE_READ, 8'h00, POS_W'(CELLS - 1));
      send_request(MODE_READ, 8'hFF, POS_W'(CELLS));
      send_request(MODE_READ, 8'hFF, '1);
      send_request(MODE_UNUSED, 8'hFF, '1);
      send_request(MODE_PUT, CHAR_BACKSPACE, '0);
      send_request(MODE_PUT, 8'h00, '1);
      send_request(MODE_PUT, 8'hFF, '0);
      send_request(MODE_PUT, 8'h09, '0);
      send_request(MODE_PUT, 8'h0D, '0);
      send_request(MODE_PUT, CHAR_BACKSPACE, '0);
      send_request(MODE_READ, 8'h00, POS_W'(1));
      send_request(MODE_READ, 8'h00, POS_W'(3));
      send_request(MODE_PUT, CHAR_NEWLINE, '0);
      send_request(MODE_PUT, CHAR_BACKSPACE, '0);
      send_request(MODE_READ, 8'h00, POS_W'(COLUMNS - 1));
      send_request(MODE_PUT, 8'h41, '0);
      send_request(MODE_READ, 8'h00, POS_W'(COLUMNS - 1));
      send_request(MODE_CLEAR, 8'hFF, '1);
      send_request(MODE_READ, 8'h00, '0);
      send_request(MODE_READ, 8'h00, POS_W'(CELLS - 1));

      for (int p = 0; p < PHASES; p++) begin
         wait_drained();
         write_color(colors[p]);
         quiet = (p == PHASES - 1);
         burst_at = $urandom_range(10, PHASE_ITEMS - 50);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 50 == 0) begin
               case ($urandom_range(0, 2))
                  0:       gap_pct = 0;
                  1:       gap_pct = 10;
                  default: gap_pct = 30;
               endcase
            end
            if (n == burst_at) begin
               // newlines toward the bottom row, then a long line that wraps and may scroll
               repeat ($urandom_range(20, 30))
                  send_request(MODE_PUT, CHAR_NEWLINE, POS_W'($urandom));
               repeat ($urandom_range(81, 200))
                  send_request(MODE_PUT, 8'($urandom_range(8'h20, 8'h7E)), POS_W'($urandom));
            end
            send_random_request();
         end
      end

      wait_drained();
      repeat (CELLS + 20) @(negedge clock);

      $display("covered %0d puts, %0d cell reads, %0d clears, %0d unused-mode requests",
               shadow.puts, shadow.reads, shadow.clears, shadow.unused);
      $display("%0d scrolls over %0d text colors, %0d responses checked, %0d mismatches",
               shadow.scrolls, PHASES + 1, shadow.responses, shadow.errors);
      if (shadow.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
